>>> rtl/sfp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfp_pkg
// Types and constants shared by the sonar frame parser modules.
// ----------------------------------------------------------------------------
package sfp_pkg;

	localparam logic [7:0] SYNC_BYTE    = 8'hFE;
	localparam logic [7:0] ID_BYTE      = 8'h05;
	localparam int         HDR_OVERHEAD = 6;
	localparam int         CH0_BIT      = 0;
	localparam int         CH1_BIT      = 1;

	typedef enum logic [3:0] {
		PH_IDLE   = 4'd0,
		PH_START  = 4'd1,
		PH_SIZE_H = 4'd2,
		PH_SIZE_L = 4'd3,
		PH_TYPE   = 4'd4,
		PH_SEQ    = 4'd5,
		PH_SIDES  = 4'd6,
		PH_TIME_H = 4'd7,
		PH_TIME_L = 4'd8,
		PH_DATA   = 4'd9,
		PH_CHK    = 4'd10
	} sfp_phase_t;

	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_DATA  = 2'd1,
		EV_FRAME = 2'd2
	} sfp_event_t;

	// classified byte handed from the parser to the output side
	typedef struct packed {
		sfp_event_t  kind;
		logic        chan;
		logic [15:0] num;
		logic [7:0]  value;
		logic [7:0]  sum;
		logic [7:0]  ftype;
		logic [7:0]  fseq;
		logic [15:0] ftime;
		logic        on0;
		logic        on1;
	} sfp_rec_t;

	typedef struct packed {
		logic     valid;
		sfp_rec_t rec;
	} sfp_beat_t;

	typedef struct packed {
		logic        data_valid;
		logic        data_channel;
		logic [15:0] sample_index;
		logic [7:0]  sample_value;
		logic        frame_end;
		logic        frame_good;
		logic [7:0]  frame_type;
		logic [7:0]  frame_sequence;
		logic [15:0] frame_time;
		logic [15:0] channel0_count;
		logic [15:0] channel1_count;
	} sfp_res_t;

endpackage
`default_nettype wire

>>> rtl/sfp_stream_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfp stream interfaces
// Byte input channel and result output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sfp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source(output valid, output rx_byte, input ready);
	modport sink(input valid, input rx_byte, output ready);
endinterface

interface sfp_tx_if;
	logic        valid;
	logic        ready;
	logic        data_valid;
	logic        data_channel;
	logic [15:0] sample_index;
	logic [7:0]  sample_value;
	logic        frame_end;
	logic        frame_good;
	logic [7:0]  frame_type;
	logic [7:0]  frame_sequence;
	logic [15:0] frame_time;
	logic [15:0] channel0_count;
	logic [15:0] channel1_count;

	modport source(
		output valid, output data_valid, output data_channel, output sample_index,
		output sample_value, output frame_end, output frame_good, output frame_type,
		output frame_sequence, output frame_time, output channel0_count,
		output channel1_count, input ready
	);
	modport sink(
		input valid, input data_valid, input data_channel, input sample_index,
		input sample_value, input frame_end, input frame_good, input frame_type,
		input frame_sequence, input frame_time, input channel0_count,
		input channel1_count, output ready
	);
endinterface
`default_nettype wire

>>> rtl/sonar_frame_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sonar_frame_parser
// Byte-serial deframer for sonar packets with a streamed sample output.
// ----------------------------------------------------------------------------
// Every accepted byte produces exactly one result beat: a sample beat for a
// data byte of an active channel, a frame report for the checksum byte, and
// an all-zero beat otherwise. The block takes one byte per clock while the
// queue is not full; the parser state machine updates its state once per
// byte. A result is written into the queue and then into the output register,
// from which it is presented to the sink. A two-entry queue and an output
// register let the input keep flowing while a result waits: up to three
// bytes are taken while the sink stalls, and once the queue is full the
// input resumes in the cycle after the sink takes a beat.
module sonar_frame_parser (
	input wire logic clk,
	input wire logic arst_n,
	sfp_rx_if.sink   rx,
	sfp_tx_if.source tx
);
	import sfp_pkg::*;

	sfp_beat_t push;
	sfp_beat_t head;
	logic      full;
	logic      pop;

	sfp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.full   (full),
		.push   (push)
	);

	sfp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.pop    (pop),
		.head   (head)
	);

	sfp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.tx     (tx)
	);

`ifndef ASSERT_OFF
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		tx.valid |-> !(tx.data_valid && tx.frame_end))
		else $error("beat is both sample and frame report");
	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		tx.valid && !tx.data_valid |-> tx.sample_index == 16'd0 && tx.sample_value == 8'd0)
		else $error("sample fields set on a non-sample beat");
	a_frame_zero: assert property (@(posedge clk) disable iff (!arst_n)
		tx.valid && !tx.frame_end |-> !tx.frame_good && tx.channel0_count == 16'd0)
		else $error("frame fields set on a non-report beat");
	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid && !pop |=> head.valid)
		else $error("accepted byte did not reach the queue");
`endif

endmodule
`default_nettype wire

>>> rtl/sfp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfp_front
// Frame parser state machine: takes one byte per beat and classifies it.
// ----------------------------------------------------------------------------
module sfp_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	sfp_rx_if.sink             rx,
	input  wire logic          full,
	output sfp_pkg::sfp_beat_t push
);
	import sfp_pkg::*;

	sfp_phase_t  phase_q, phase_d;
	logic [7:0]  sum_q, sum_d;
	logic [15:0] len_q, len_d;
	logic [7:0]  type_q, type_d;
	logic [7:0]  seq_q, seq_d;
	logic [15:0] time_q, time_d;
	logic        on0_q, on0_d;
	logic        on1_q, on1_d;
	logic [16:0] count_q, count_d;
	logic        turn_q, turn_d;
	sfp_rec_t    rec;
	logic        fire;
	logic        both;
	logic        ended;
	logic signed [17:0] thresh;
	logic [7:0]  b;

	assign b        = rx.rx_byte;
	assign rx.ready = !full;
	assign fire     = rx.valid && !full;
	assign both     = on0_q && on1_q;
	assign thresh   = $signed({{2{len_q[15]}}, len_q}) - 18'(HDR_OVERHEAD);
	// data count is never negative, so zero extend before the signed compare
	assign ended    = $signed({1'b0, count_q}) > thresh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			sum_q   <= '0;
			len_q   <= '0;
			type_q  <= '0;
			seq_q   <= '0;
			time_q  <= '0;
			on0_q   <= 1'b0;
			on1_q   <= 1'b0;
			count_q <= '0;
			turn_q  <= 1'b1;
		end else if (fire) begin
			phase_q <= phase_d;
			sum_q   <= sum_d;
			len_q   <= len_d;
			type_q  <= type_d;
			seq_q   <= seq_d;
			time_q  <= time_d;
			on0_q   <= on0_d;
			on1_q   <= on1_d;
			count_q <= count_d;
			turn_q  <= turn_d;
		end
	end

	always_comb begin
		phase_d   = phase_q;
		sum_d     = sum_q + b;
		len_d     = len_q;
		type_d    = type_q;
		seq_d     = seq_q;
		time_d    = time_q;
		on0_d     = on0_q;
		on1_d     = on1_q;
		count_d   = count_q;
		turn_d    = turn_q;
		rec       = '0;
		rec.kind  = EV_NONE;
		rec.value = b;
		unique case (phase_q)
			PH_IDLE: begin
				if (b == SYNC_BYTE) begin
					phase_d = PH_START;
					count_d = '0;
					turn_d  = 1'b1;
					sum_d   = b;
				end
			end
			PH_START: phase_d = (b == ID_BYTE) ? PH_SIZE_H : PH_IDLE;
			PH_SIZE_H: begin
				len_d   = {b, 8'h00};
				phase_d = PH_SIZE_L;
			end
			PH_SIZE_L: begin
				len_d   = {len_q[15:8], b};
				phase_d = PH_TYPE;
			end
			PH_TYPE: begin
				type_d  = b;
				phase_d = PH_SEQ;
			end
			PH_SEQ: begin
				seq_d   = b;
				phase_d = PH_SIDES;
			end
			PH_SIDES: begin
				on0_d   = b[CH0_BIT];
				on1_d   = b[CH1_BIT];
				phase_d = PH_TIME_H;
			end
			PH_TIME_H: begin
				time_d  = {b, 8'h00};
				phase_d = PH_TIME_L;
			end
			PH_TIME_L: begin
				time_d  = {time_q[15:8], b};
				phase_d = PH_DATA;
			end
			PH_DATA: begin
				if (on0_q || on1_q) begin
					rec.kind = EV_DATA;
				end
				if (both) begin
					rec.chan = !turn_q;
					rec.num  = count_q[16:1];
					turn_d   = !turn_q;
				end else begin
					rec.chan = !on0_q;
					rec.num  = count_q[15:0];
				end
				count_d = count_q + 17'd1;
				if (ended) begin
					phase_d = PH_CHK;
					// two channels report the per-channel count
					if (both) begin
						count_d = {1'b0, count_q[16:1]} + 17'd1;
					end
				end
			end
			PH_CHK: begin
				rec.kind  = EV_FRAME;
				rec.num   = count_q[15:0];
				rec.sum   = sum_q;
				rec.ftype = type_q;
				rec.fseq  = seq_q;
				rec.ftime = time_q;
				rec.on0   = on0_q;
				rec.on1   = on1_q;
				sum_d     = '0;
				phase_d   = PH_IDLE;
			end
			default: begin
				sum_d   = sum_q;
				phase_d = PH_IDLE;
			end
		endcase
	end

	assign push.valid = fire;
	assign push.rec   = rec;

endmodule
`default_nettype wire

>>> rtl/sfp_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfp_queue
// Two-entry queue between the parser and the output side.
// ----------------------------------------------------------------------------
module sfp_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire sfp_pkg::sfp_beat_t push,
	output logic                    full,
	input  wire logic               pop,
	output sfp_pkg::sfp_beat_t      head
);
	import sfp_pkg::*;

	sfp_rec_t    mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  fill_q;
	logic        do_push;
	logic        do_pop;

	assign full       = fill_q == 2'd2;
	assign head.valid = fill_q != 2'd0;
	assign head.rec   = mem_q[rd_ptr_q];
	assign do_push    = push.valid && !full;
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			fill_q <= fill_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

`ifndef ASSERT_OFF
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q != 2'd3)
		else $error("queue fill out of range");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full && !do_pop |=> full)
		else $error("queue lost an entry while full");
	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == 2'd0 || fill_q == 2'd2) |-> wr_ptr_q == rd_ptr_q)
		else $error("queue pointers disagree with fill level");
`endif

endmodule
`default_nettype wire

>>> rtl/sfp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfp_back
// Builds the result beat from a classified byte and holds it for the sink.
// ----------------------------------------------------------------------------
module sfp_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire sfp_pkg::sfp_beat_t head,
	output logic                    pop,
	sfp_tx_if.source                tx
);
	import sfp_pkg::*;

	sfp_res_t res;
	sfp_res_t res_q;
	logic     valid_q;

	assign pop = head.valid && (!valid_q || tx.ready);

	always_comb begin
		res = '0;
		unique case (head.rec.kind)
			EV_DATA: begin
				res.data_valid   = 1'b1;
				res.data_channel = head.rec.chan;
				res.sample_index = head.rec.num;
				res.sample_value = head.rec.value;
			end
			EV_FRAME: begin
				res.frame_end      = 1'b1;
				res.frame_good     = head.rec.sum == head.rec.value;
				res.frame_type     = head.rec.ftype;
				res.frame_sequence = head.rec.fseq;
				res.frame_time     = head.rec.ftime;
				res.channel0_count = head.rec.on0 ? head.rec.num : 16'd0;
				res.channel1_count = head.rec.on1 ? head.rec.num : 16'd0;
			end
			default: res = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (tx.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res;
		end
	end

	assign tx.valid          = valid_q;
	assign tx.data_valid     = res_q.data_valid;
	assign tx.data_channel   = res_q.data_channel;
	assign tx.sample_index   = res_q.sample_index;
	assign tx.sample_value   = res_q.sample_value;
	assign tx.frame_end      = res_q.frame_end;
	assign tx.frame_good     = res_q.frame_good;
	assign tx.frame_type     = res_q.frame_type;
	assign tx.frame_sequence = res_q.frame_sequence;
	assign tx.frame_time     = res_q.frame_time;
	assign tx.channel0_count = res_q.channel0_count;
	assign tx.channel1_count = res_q.channel1_count;

endmodule
`default_nettype wire
